// File: hdl/crcft_pkg.sv
`default_nettype none

package crcft_pkg;

	localparam int unsigned TailDepth = 4;
	localparam int unsigned SeenWidth = 3;

	localparam logic [7:0] TRAILER_FIRST_RESET = 8'hab;
	localparam logic [7:0] TRAILER_SECOND_RESET = 8'hcd;

	localparam logic [0:0] REG_TRAILER_FIRST = 1'b0;
	localparam logic [0:0] REG_TRAILER_SECOND = 1'b1;

	localparam logic [15:0] CRC_TOP_MASK = 16'hf000;

	localparam logic [15:0] NIB_TABLE [16] = '{
		16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
		16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
	};

	typedef struct packed {
		logic frame_ok;
		logic frame_short;
	} result_t;

	function automatic logic [15:0] nibble_step(input logic [15:0] crc, input logic [3:0] nib);
		logic [3:0] top;
		top = 4'((crc & CRC_TOP_MASK) >> 12);
		return {crc[11:0], 4'b0000} ^ NIB_TABLE[top ^ nib];
	endfunction

	function automatic logic [15:0] byte_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] mid;
		mid = nibble_step(crc, b[7:4]);
		return nibble_step(mid, b[3:0]);
	endfunction

endpackage

`default_nettype wire

// File: hdl/crcft_frame.sv
`default_nettype none

module crcft_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	input  wire logic [7:0]         trailer_first,
	input  wire logic [7:0]         trailer_second,
	output crcft_pkg::result_t      result
);

	logic [15:0] crc_q;
	logic [7:0]  tail_q [crcft_pkg::TailDepth];
	logic [crcft_pkg::SeenWidth-1:0] bytes_seen_q;

	logic [15:0] crc_next;
	logic [7:0]  tail_next [crcft_pkg::TailDepth];
	logic [crcft_pkg::SeenWidth-1:0] seen_next;
	logic        body_full;

	always_comb begin
		body_full = (bytes_seen_q >= crcft_pkg::SeenWidth'(crcft_pkg::TailDepth));
		crc_next = body_full ? crcft_pkg::byte_step(crc_q, tail_q[0]) : crc_q;
		for (int i = 0; i < crcft_pkg::TailDepth - 1; i++) begin
			tail_next[i] = tail_q[i + 1];
		end
		tail_next[crcft_pkg::TailDepth - 1] = data_byte;
		seen_next = body_full ? bytes_seen_q : bytes_seen_q + 1'b1;

		result.frame_short = (seen_next < crcft_pkg::SeenWidth'(crcft_pkg::TailDepth));
		result.frame_ok = !result.frame_short
			&& (tail_next[0] == crc_next[7:0])
			&& (tail_next[1] == crc_next[15:8])
			&& (tail_next[2] == trailer_first)
			&& (tail_next[3] == trailer_second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			bytes_seen_q <= '0;
			for (int i = 0; i < crcft_pkg::TailDepth; i++) begin
				tail_q[i] <= '0;
			end
		end else if (step) begin
			if (last_byte) begin
				crc_q <= '0;
				bytes_seen_q <= '0;
				for (int i = 0; i < crcft_pkg::TailDepth; i++) begin
					tail_q[i] <= '0;
				end
			end else begin
				crc_q <= crc_next;
				bytes_seen_q <= seen_next;
				tail_q <= tail_next;
			end
		end
	end

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= crcft_pkg::SeenWidth'(crcft_pkg::TailDepth))
		else $error("byte count above tail depth");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> bytes_seen_q == '0 && crc_q == '0)
		else $error("frame state not cleared after last byte");

	a_crc_idle_short: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q < crcft_pkg::SeenWidth'(crcft_pkg::TailDepth) |-> crc_q == '0)
		else $error("crc moved before the body started");

endmodule

`default_nettype wire

// File: hdl/crc16_frame_trailer_check.sv
// CRC-16 frame trailer checker.
// Frame bytes enter on the input channel (data_byte, last_byte) under
// in_valid/in_ready, one byte per item. The CRC (polynomial 0x1021, start
// value zero, no reflection, no final XOR) runs over all bytes but the last
// four; those four must be CRC low byte, CRC high byte, trailer_first and
// trailer_second. Only the item marked last_byte gives a result on the output
// channel (frame_ok, frame_short) under out_valid/out_ready. A frame of fewer
// than four bytes reports frame_short with frame_ok low.
// An accepted item is held in the input register and its result is then
// registered in the output register, which raises out_valid. One byte is
// taken every cycle while no last byte waits on a pending result; the CRC
// update is one byte through a two-step nibble table.
// Trailer registers are written through cfg_we, cfg_index and cfg_wdata; the
// user must do so only while the block is idle, which it does not enforce.
// Reset loads 0xab and 0xcd and clears frame state. When the receiver stalls
// with a result pending, non-last bytes still go through; a last byte waits
// in the input register, and in_ready drops until the pending result is taken.
`default_nettype none

module crc16_frame_trailer_check (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            frame_ok,
	output logic            frame_short,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0] trailer_first_q;
	logic [7:0] trailer_second_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	logic       out_valid_q;
	crcft_pkg::result_t result_q;
	crcft_pkg::result_t result;

	logic advance;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trailer_first_q <= crcft_pkg::TRAILER_FIRST_RESET;
			trailer_second_q <= crcft_pkg::TRAILER_SECOND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crcft_pkg::REG_TRAILER_FIRST: trailer_first_q <= cfg_wdata;
				crcft_pkg::REG_TRAILER_SECOND: trailer_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	crcft_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.data_byte      (data_s1),
		.last_byte      (last_s1),
		.trailer_first  (trailer_first_q),
		.trailer_second (trailer_second_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_ok = result_q.frame_ok;
	assign frame_short = result_q.frame_short;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && last_s1))
		else $error("pending result overwritten");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.frame_ok && result_q.frame_short))
		else $error("frame reported both good and short");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q)
		else $error("last byte processed without a result");

endmodule

`default_nettype wire
